// ===== hw/rtl/xsfb_pkg.sv =====
// Shared types, constants and modulo tables for the XOR sprite framebuffer.
`default_nettype none

package xsfb_pkg;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	localparam int COL_W      = $clog2(SCREEN_WIDTH);
	localparam int LINE_W     = $clog2(SCREEN_HEIGHT);
	localparam int SPRITE_W   = 8;
	localparam int ROW_BITS_W = 64;
	localparam int TAB_DEPTH  = 256;

	localparam logic [COL_W:0]  WIDTH_EXT  = (COL_W + 1)'(SCREEN_WIDTH);
	localparam logic [LINE_W:0] HEIGHT_EXT = (LINE_W + 1)'(SCREEN_HEIGHT);

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_DRAW  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_ACK   = 2'd3
	} func_t;

	typedef logic [LINE_W-1:0]       line_t;
	typedef logic [COL_W-1:0]        col_t;
	typedef logic [SCREEN_WIDTH-1:0] pix_row_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [3:0] row_index;
		logic [7:0] spr_bits;
		logic [4:0] read_line;
	} in_word_t;

	typedef struct packed {
		logic                  collision;
		logic [ROW_BITS_W-1:0] row_bits;
		logic                  frame_dirty;
	} out_word_t;

	// control between sequencer and row memory
	typedef struct packed {
		logic  rd_en;
		line_t rd_addr;
		logic  wr_en;
		line_t wr_addr;
		logic  clr;
	} mem_ctl_t;

	typedef line_t line_tab_t [TAB_DEPTH];
	typedef col_t  col_tab_t  [TAB_DEPTH];

	function automatic line_tab_t build_line_tab();
		line_tab_t tab;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			tab[i] = LINE_W'(i % SCREEN_HEIGHT);
		end
		return tab;
	endfunction

	function automatic col_tab_t build_col_tab();
		col_tab_t tab;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			tab[i] = COL_W'(i % SCREEN_WIDTH);
		end
		return tab;
	endfunction

	// v mod height / v mod width for 8-bit v
	localparam line_tab_t LINE_MOD_TAB = build_line_tab();
	localparam col_tab_t  COL_MOD_TAB  = build_col_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/xor_sprite_framebuffer_unit.sv =====
// Top level of the XOR sprite framebuffer: sequencer, flags and result register.
// Flow: an accepted request word waits in stage 1 for the row memory read and
//   write-back of its line, then moves on to the result register; a full result
//   register that is stalled holds it there. One item in stage 1 at a time.
// Reset: asynchronous; flags and per-line valid bits clear at once, so the whole
//   frame reads as off immediately, with no clearing pass.
`default_nettype none

module xor_sprite_framebuffer_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  xsfb_pkg::in_word_t   req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output xsfb_pkg::out_word_t  rsp
);
	import xsfb_pkg::*;

	// stage 1 holds the accepted word while its line comes back from memory
	logic      valid_s1;
	in_word_t  item_s1;
	line_t     line_s1;
	pix_row_t  mask_s1;

	logic      coll_q;
	logic      dirty_q;
	logic      rsp_valid_q;
	out_word_t rsp_q;

	logic      accept;
	logic      done;
	line_t     calc_line;
	pix_row_t  calc_mask;
	mem_ctl_t  mem_ctl;
	pix_row_t  old_row;
	pix_row_t  new_row;
	logic      hit;
	logic      coll_next;
	logic      dirty_next;
	out_word_t rsp_next;

	// one word at a time: the row memory is busy for the read-modify-write
	assign req_stall = valid_s1;
	assign accept    = req_valid && !valid_s1;
	// finish once the result register is free or being emptied this cycle
	assign done      = valid_s1 && (!rsp_valid_q || !rsp_stall);

	xsfb_draw_calc u_calc (
		.word (req),
		.line (calc_line),
		.mask (calc_mask)
	);

	// read on accept, write back (or clear) on completion; never both at once
	always_comb begin
		mem_ctl.rd_en   = accept;
		mem_ctl.rd_addr = calc_line;
		mem_ctl.wr_en   = done && (item_s1.func == FUNC_DRAW);
		mem_ctl.wr_addr = line_s1;
		mem_ctl.clr     = done && (item_s1.func == FUNC_CLEAR);
	end

	xsfb_line_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_data (new_row),
		.rd_data (old_row)
	);

	// XOR the sprite in; any lit pixel switched off is a collision
	assign new_row = old_row ^ mask_s1;
	assign hit     = |(old_row & mask_s1);

	always_comb begin
		coll_next  = coll_q;
		dirty_next = dirty_q;
		rsp_next   = '0;
		unique case (item_s1.func)
			FUNC_CLEAR: begin
				dirty_next = 1'b1;
			end
			FUNC_DRAW: begin
				// row 0 opens a new sprite, so the flag restarts
				coll_next         = ((item_s1.row_index != 4'd0) && coll_q) || hit;
				dirty_next        = 1'b1;
				rsp_next.row_bits = ROW_BITS_W'(new_row);
			end
			FUNC_READ: begin
				rsp_next.row_bits = ROW_BITS_W'(old_row);
			end
			FUNC_ACK: begin
				dirty_next = 1'b0;
			end
			default: begin
				dirty_next = dirty_q;
			end
		endcase
		rsp_next.collision   = coll_next;
		rsp_next.frame_dirty = dirty_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			coll_q      <= 1'b0;
			dirty_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				coll_q      <= coll_next;
				dirty_q     <= dirty_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
			line_s1 <= calc_line;
			mask_s1 <= calc_mask;
		end
		if (done) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// read of a new word never overlaps write-back of the previous one
	a_no_rw_overlap : assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |-> !(mem_ctl.wr_en || mem_ctl.clr))
		else $error("row memory read overlaps write-back");

	// an acknowledge leaves the frame clean in its result
	a_ack_clears_dirty : assert property (@(posedge clk) disable iff (!arst_n)
		(done && (item_s1.func == FUNC_ACK)) |=> (rsp_valid && !rsp.frame_dirty))
		else $error("acknowledge did not clear dirty flag");

	// a draw always marks the frame dirty
	a_draw_sets_dirty : assert property (@(posedge clk) disable iff (!arst_n)
		(done && (item_s1.func == FUNC_DRAW)) |=> (rsp_valid && rsp.frame_dirty && dirty_q))
		else $error("draw did not set dirty flag");

endmodule

`default_nettype wire

// ===== hw/rtl/xsfb_line_mem.sv =====
// Row memory of the framebuffer with per-line valid bits, so a clear needs no pass over the lines.
`default_nettype none

module xsfb_line_mem (
	input  wire                     clk,
	input  wire                     arst_n,
	input  xsfb_pkg::mem_ctl_t      ctl,
	input  xsfb_pkg::pix_row_t      wr_data,
	output xsfb_pkg::pix_row_t      rd_data
);
	import xsfb_pkg::*;

	pix_row_t                 mem_q [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] valid_q;
	pix_row_t                 rd_data_q;
	logic                     rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ctl.rd_addr];
			end
		end
	end

	// unwritten or cleared lines read as all pixels off
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/xsfb_draw_calc.sv =====
// Line address and column toggle mask for one incoming word.
`default_nettype none

module xsfb_draw_calc (
	input  xsfb_pkg::in_word_t word,
	output xsfb_pkg::line_t    line,
	output xsfb_pkg::pix_row_t mask
);
	import xsfb_pkg::*;

	line_t       y_mod;
	line_t       r_mod;
	logic [LINE_W:0] line_sum;
	line_t       draw_line;
	col_t        x_mod;

	assign y_mod    = LINE_MOD_TAB[word.y_pos];
	assign r_mod    = LINE_MOD_TAB[8'(word.row_index)];
	assign line_sum = {1'b0, y_mod} + {1'b0, r_mod};

	always_comb begin
		if (line_sum >= HEIGHT_EXT) begin
			draw_line = LINE_W'(line_sum - HEIGHT_EXT);
		end else begin
			draw_line = LINE_W'(line_sum);
		end
	end

	assign line = (word.func == FUNC_READ) ? LINE_MOD_TAB[8'(word.read_line)] : draw_line;

	assign x_mod = COL_MOD_TAB[word.x_pos];

	// bit 7 of the sprite lands on column x, bit 0 on x+7, each wrapped
	always_comb begin
		logic [COL_W:0] pos;
		mask = '0;
		for (int c = 0; c < SPRITE_W; c++) begin
			pos = {1'b0, x_mod} + (COL_W + 1)'(c);
			if (pos >= WIDTH_EXT) begin
				pos = pos - WIDTH_EXT;
			end
			if (word.spr_bits[SPRITE_W-1-c]) begin
				mask[pos[COL_W-1:0]] = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_xor_sprite_framebuffer_unit.sv =====
// Self-checking testbench for the XOR sprite framebuffer unit: directed table, then random traffic.
module tb_xor_sprite_framebuffer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import xsfb_pkg::*;

	localparam int IDLE_LIMIT  = 4000; // cycles with no word moving on either side
	localparam int WORD_TARGET = 1500;
	localparam int HOLD_AFTER  = 400;  // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 8;    // leave some margin for stray words
	localparam int DIR_ROWS    = 23;

	// one directed row: request fields, then an optional hand-typed result
	typedef struct packed {
		func_t       fn;
		logic [7:0]  xp;
		logic [7:0]  yp;
		logic [3:0]  ri;
		logic [7:0]  sb;
		logic [4:0]  rl;
		logic        typed;
		logic        e_coll;
		logic [63:0] e_bits;
		logic        e_dirty;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// fresh frame reads back blank, whatever the line
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b0, 64'h0, 1'b0},
		'{FUNC_READ,  8'd255, 8'd255, 4'd15, 8'hFF, 5'd31, 1'b1, 1'b0, 64'h0, 1'b0},
		'{FUNC_ACK,   8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b0, 64'h0, 1'b0},
		// single pixel on, then off again: that second draw is a collision
		'{FUNC_DRAW,  8'd0,   8'd0,   4'd0,  8'h80, 5'd0,  1'b1, 1'b0, 64'h1, 1'b1},
		'{FUNC_DRAW,  8'd0,   8'd0,   4'd0,  8'h80, 5'd0,  1'b1, 1'b1, 64'h0, 1'b1},
		// empty byte on a later row keeps the collision, on row 0 it clears it
		'{FUNC_DRAW,  8'd0,   8'd0,   4'd1,  8'h00, 5'd0,  1'b1, 1'b1, 64'h0, 1'b1},
		'{FUNC_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b0, 64'h0, 1'b1},
		'{FUNC_ACK,   8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b0, 64'h0, 1'b0},
		// largest origin and row: wraps on both axes, lands on line 14
		'{FUNC_DRAW,  8'd255, 8'd255, 4'd15, 8'hFF, 5'd0,  1'b1, 1'b0,
			64'h8000_0000_0000_007F, 1'b1},
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd14, 1'b1, 1'b0,
			64'h8000_0000_0000_007F, 1'b1},
		'{FUNC_DRAW,  8'd60,  8'd0,   4'd3,  8'hFF, 5'd0,  1'b1, 1'b0,
			64'hF000_0000_0000_000F, 1'b1},
		'{FUNC_DRAW,  8'd62,  8'd31,  4'd1,  8'hAA, 5'd0,  1'b0, 1'b0, 64'h0, 1'b0},
		'{FUNC_DRAW,  8'd62,  8'd31,  4'd1,  8'h80, 5'd0,  1'b0, 1'b0, 64'h0, 1'b0},
		// clear leaves the collision flag alone
		'{FUNC_CLEAR, 8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b1, 64'h0, 1'b1},
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b1, 64'h0, 1'b1},
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd3,  1'b1, 1'b1, 64'h0, 1'b1},
		'{FUNC_ACK,   8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b1, 1'b1, 64'h0, 1'b0},
		'{FUNC_DRAW,  8'd128, 8'd128, 4'd0,  8'h55, 5'd0,  1'b0, 1'b0, 64'h0, 1'b0},
		'{FUNC_DRAW,  8'd127, 8'd127, 4'd8,  8'h01, 5'd0,  1'b0, 1'b0, 64'h0, 1'b0},
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd31, 1'b0, 1'b0, 64'h0, 1'b0},
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd16, 1'b0, 1'b0, 64'h0, 1'b0},
		'{FUNC_READ,  8'd0,   8'd0,   4'd0,  8'h00, 5'd7,  1'b0, 1'b0, 64'h0, 1'b0},
		'{FUNC_ACK,   8'd0,   8'd0,   4'd0,  8'h00, 5'd0,  1'b0, 1'b0, 64'h0, 1'b0}
	};

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_word_t  req;
	logic      rsp_valid;
	logic      rsp_stall;
	out_word_t rsp;

	// shadow copy of the frame and its two flags
	pix_row_t  frame_copy [SCREEN_HEIGHT];
	logic      coll_copy;
	logic      dirty_copy;

	out_word_t due_rsp [$];
	out_word_t want;
	int        err_cnt = 0;
	int        sent_words;
	int        words_seen = 0;
	int        idle_cycles = 0;

	xor_sprite_framebuffer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request word to the shadow frame and returns the word the
	// block should answer with.
	function automatic out_word_t frame_step(input in_word_t w);
		out_word_t   o;
		pix_row_t    bits;
		int unsigned ln;
		int unsigned px;
		o    = '0;
		bits = '0;
		case (w.func)
		FUNC_CLEAR: begin
			foreach (frame_copy[i]) frame_copy[i] = '0;
			dirty_copy = 1'b1;
		end
		FUNC_DRAW: begin
			// y plus row can run past 255, so add at full width
			ln   = (int'(w.y_pos) + int'(w.row_index)) % SCREEN_HEIGHT;
			bits = frame_copy[ln];
			if (w.row_index == 4'd0) coll_copy = 1'b0;
			for (int c = 0; c < 8; c++) begin
				if (w.spr_bits[7-c]) begin
					px = (int'(w.x_pos) + c) % SCREEN_WIDTH;
					if (bits[px]) coll_copy = 1'b1;
					bits[px] = ~bits[px];
				end
			end
			frame_copy[ln] = bits;
			dirty_copy     = 1'b1;
		end
		FUNC_READ: begin
			bits = frame_copy[int'(w.read_line) % SCREEN_HEIGHT];
		end
		default: begin
			dirty_copy = 1'b0;
		end
		endcase
		o.collision   = coll_copy;
		o.row_bits    = bits;
		o.frame_dirty = dirty_copy;
		return o;
	endfunction

	function automatic in_word_t rand_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_word_t)-1:0];
	endfunction

	// Offers one word after a random gap, waits for it to be taken, then
	// queues the answer: the hand-typed one if given, else the predicted one.
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t hand);
		int unsigned gap;
		int unsigned r;
		out_word_t   pred;
		r = $urandom_range(0, 99);
		if ((sent_words / 100) % 4 == 3) gap = 0; // a calm stretch every so often
		else if (r < 65)                  gap = 0;
		else if (r < 93)                  gap = $urandom_range(1, 3);
		else                              gap = $urandom_range(8, 30);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pred = frame_step(w);
		due_rsp.push_back(typed ? hand : pred);
		sent_words++;
	endtask

	// Response checker: every word taken is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsp.size() == 0) begin
				$error("result word with nothing expected: %h", rsp);
				err_cnt++;
			end else begin
				want = due_rsp.pop_front();
				if (rsp.collision !== want.collision) begin
					$error("collision: expected %0b, got %0b", want.collision, rsp.collision);
					err_cnt++;
				end
				if (rsp.row_bits !== want.row_bits) begin
					$error("row_bits: expected %h, got %h", want.row_bits, rsp.row_bits);
					err_cnt++;
				end
				if (rsp.frame_dirty !== want.frame_dirty) begin
					$error("frame_dirty: expected %0b, got %0b", want.frame_dirty,
						rsp.frame_dirty);
					err_cnt++;
				end
			end
			words_seen++;
		end
	end

	// Receiver back-pressure: mostly short stalls, some long, calm windows,
	// and one long hold-off so the block backs up into its input.
	initial begin : rsp_side
		int unsigned hold;
		int unsigned cyc;
		int unsigned r;
		bit          held;
		hold      = 0;
		cyc       = 0;
		held      = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (!held && words_seen >= HOLD_AFTER) begin
					held = 1'b1;
					hold = HOLD_CYCLES;
				end else if (cyc % 512 < 96) begin
					hold = 0;
				end else if (r < 60) begin
					hold = 0;
				end else if (r < 94) begin
					hold = $urandom_range(1, 3);
				end else begin
					hold = $urandom_range(10, 40);
				end
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long with nothing moving on either channel means a hang.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : req_side
		in_word_t   w;
		logic [7:0] sx;
		logic [7:0] sy;
		int         h;
		int         r;
		int         n;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		sent_words  = 0;
		coll_copy   = 1'b0;
		dirty_copy  = 1'b0;
		sx          = '0;
		sy          = '0;
		foreach (frame_copy[i]) frame_copy[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			w.func        = DIR_TAB[i].fn;
			w.x_pos       = DIR_TAB[i].xp;
			w.y_pos       = DIR_TAB[i].yp;
			w.row_index   = DIR_TAB[i].ri;
			w.spr_bits    = DIR_TAB[i].sb;
			w.read_line   = DIR_TAB[i].rl;
			send_word(w, DIR_TAB[i].typed,
				'{DIR_TAB[i].e_coll, DIR_TAB[i].e_bits, DIR_TAB[i].e_dirty});
		end

		// random part: mostly whole sprites, then read bursts, acks, clears, noise
		while (sent_words < WORD_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 68) begin
				h = $urandom_range(1, 15);
				// a quarter of sprites go over the last one, to erase and collide
				if ($urandom_range(0, 3) != 0) begin
					sx = 8'($urandom);
					sy = 8'($urandom);
				end
				for (int k = 0; k < h; k++) begin
					w             = rand_word();
					w.func        = FUNC_DRAW;
					w.x_pos       = sx;
					w.y_pos       = sy;
					w.row_index   = 4'(k);
					send_word(w, 1'b0, '0);
				end
			end else if (r < 84) begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					w      = rand_word();
					w.func = FUNC_READ;
					send_word(w, 1'b0, '0);
				end
			end else if (r < 91) begin
				w      = rand_word();
				w.func = FUNC_ACK;
				send_word(w, 1'b0, '0);
			end else if (r < 94) begin
				w      = rand_word();
				w.func = FUNC_CLEAR;
				send_word(w, 1'b0, '0);
			end else begin
				send_word(rand_word(), 1'b0, '0);
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (due_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
